// ===== rtl/stwf_pkg.sv =====
// Shared types, constants and color tables for the SPI TFT window frame store.
`default_nettype none

package stwf_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int PIX_W = 24;
  localparam int CFG_IW = 3;

  localparam int MAX5 = 31;
  localparam int MAX6 = 63;
  localparam logic [7:0] READ_MASK = 8'hFC;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_COL_OP   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ROW_OP   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_WR_OP    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_RD_OP    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_X_OFFSET = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_Y_OFFSET = 3'd5;

  typedef enum logic [1:0] {
    SRC_ECHO,
    SRC_ZERO,
    SRC_PIXEL
  } reply_src_e;

  typedef struct packed {
    reply_src_e  src;
    logic [1:0]  chan;   // 0 red, 1 green, 2 blue
  } reply_info_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AW-1:0]    addr;
    logic [PIX_W-1:0] wdata;
  } mem_req_t;

  // floor(c*255/max) tables, built at elaboration
  function automatic logic [32*8-1:0] build_exp5();
    logic [32*8-1:0] t;
    t = '0;
    for (int i = 0; i < 32; i++) begin
      t[i*8 +: 8] = 8'((i * 255) / MAX5);
    end
    return t;
  endfunction

  function automatic logic [64*8-1:0] build_exp6();
    logic [64*8-1:0] t;
    t = '0;
    for (int i = 0; i < 64; i++) begin
      t[i*8 +: 8] = 8'((i * 255) / MAX6);
    end
    return t;
  endfunction

  localparam logic [32*8-1:0] EXP5_TBL = build_exp5();
  localparam logic [64*8-1:0] EXP6_TBL = build_exp6();

endpackage

`default_nettype wire

// ===== rtl/stwf_ram.sv =====
// Single-port synchronous RAM with registered read data.
`default_nettype none

module stwf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stwf_ctrl.sv =====
// Command decoder, window walker and frame store request generation.
`default_nettype none

module stwf_ctrl
  import stwf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [CFG_IW-1:0] cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              step_i,
  input  wire logic              is_data_i,
  input  wire logic [7:0]        bus_byte_i,
  output reply_info_t            info_o,
  output mem_req_t               req_o
);

  typedef enum logic [2:0] {
    PH_INITIAL,
    PH_IGNORE,
    PH_COLSET,
    PH_ROWSET,
    PH_WRITE,
    PH_READ_DUMMY,
    PH_READ
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  high_q, high_d;
  logic [15:0] col_first_q, col_first_d, col_last_q, col_last_d;
  logic [15:0] row_first_q, row_first_d, row_last_q, row_last_d;
  logic [16:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;

  logic [7:0]  col_op_q, row_op_q, wr_op_q, rd_op_q;
  logic [15:0] x_off_q, y_off_q;

  // screen position of the current window point
  logic [17:0]   x_diff, y_diff;
  logic          on_screen;
  logic [AW-1:0] pix_addr;

  assign x_diff    = {1'b0, cur_col_q} - {2'b00, x_off_q};
  assign y_diff    = {1'b0, cur_row_q} - {2'b00, y_off_q};
  assign on_screen = !x_diff[17] && (x_diff[16:0] < 17'(SCREEN_WIDTH)) &&
                     !y_diff[17] && (y_diff[16:0] < 17'(SCREEN_HEIGHT));
  assign pix_addr  = AW'(x_diff[XW-1:0]) +
                     AW'(AW'(y_diff[YW-1:0]) * AW'(SCREEN_WIDTH));

  // RGB565 expansion
  logic [15:0] word;
  logic [4:0]  r5, b5;
  logic [5:0]  g6;
  logic [PIX_W-1:0] rgb888;

  assign word   = {high_q, bus_byte_i};
  assign r5     = word[15:11];
  assign g6     = word[10:5];
  assign b5     = word[4:0];
  assign rgb888 = {EXP5_TBL[r5*8 +: 8], EXP6_TBL[g6*8 +: 8], EXP5_TBL[b5*8 +: 8]};

  logic [16:0] col_inc, row_inc;
  assign col_inc = cur_col_q + 17'd1;
  assign row_inc = cur_row_q + 17'd1;

  always_comb begin
    phase_d     = phase_q;
    byte_idx_d  = byte_idx_q;
    high_d      = high_q;
    col_first_d = col_first_q;
    col_last_d  = col_last_q;
    row_first_d = row_first_q;
    row_last_d  = row_last_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    info_o      = '{src: SRC_ECHO, chan: 2'd0};
    req_o       = '{we: 1'b0, re: 1'b0, addr: pix_addr, wdata: rgb888};

    if (step_i) begin
      if (!is_data_i) begin
        byte_idx_d = 2'd0;
        high_d     = 8'd0;
        if (bus_byte_i == col_op_q) begin
          phase_d = PH_COLSET;
        end else if (bus_byte_i == row_op_q) begin
          phase_d = PH_ROWSET;
        end else if (bus_byte_i == wr_op_q) begin
          cur_col_d = {1'b0, col_first_q};
          cur_row_d = {1'b0, row_first_q};
          phase_d   = PH_WRITE;
        end else if (bus_byte_i == rd_op_q) begin
          cur_col_d = {1'b0, col_first_q};
          cur_row_d = {1'b0, row_first_q};
          phase_d   = PH_READ_DUMMY;
        end else begin
          phase_d = PH_IGNORE;
        end
      end else begin
        case (phase_q)
          PH_INITIAL: begin
            info_o.src = SRC_ZERO;
          end
          PH_COLSET, PH_ROWSET: begin
            if (!byte_idx_q[0]) begin
              high_d     = bus_byte_i;
              byte_idx_d = byte_idx_q + 2'd1;
            end else if (byte_idx_q == 2'd1) begin
              if (phase_q == PH_COLSET) col_first_d = word;
              else row_first_d = word;
              byte_idx_d = 2'd2;
            end else begin
              if (phase_q == PH_COLSET) col_last_d = word;
              else row_last_d = word;
              byte_idx_d = 2'd0;
              phase_d    = PH_IGNORE;
            end
          end
          PH_WRITE: begin
            if (byte_idx_q == 2'd0) begin
              high_d     = bus_byte_i;
              byte_idx_d = 2'd1;
            end else begin
              req_o.we   = on_screen;
              byte_idx_d = 2'd0;
              if (col_inc > {1'b0, col_last_q}) begin
                cur_col_d = {1'b0, col_first_q};
                cur_row_d = row_inc;
                if (row_inc > {1'b0, row_last_q}) phase_d = PH_IGNORE;
              end else begin
                cur_col_d = col_inc;
              end
            end
          end
          PH_READ_DUMMY: begin
            byte_idx_d = 2'd0;
            phase_d    = PH_READ;
          end
          PH_READ: begin
            info_o.src  = on_screen ? SRC_PIXEL : SRC_ZERO;
            info_o.chan = byte_idx_q;
            req_o.re    = on_screen;
            if (byte_idx_q >= 2'd2) begin
              byte_idx_d = 2'd0;
              if (col_inc > {1'b0, col_last_q}) begin
                cur_col_d = {1'b0, col_first_q};
                cur_row_d = row_inc;
                if (row_inc > {1'b0, row_last_q}) phase_d = PH_IGNORE;
              end else begin
                cur_col_d = col_inc;
              end
            end else begin
              byte_idx_d = byte_idx_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_INITIAL;
      byte_idx_q  <= 2'd0;
      high_q      <= 8'd0;
      col_first_q <= 16'd0;
      col_last_q  <= 16'd0;
      row_first_q <= 16'd0;
      row_last_q  <= 16'd0;
      cur_col_q   <= 17'd0;
      cur_row_q   <= 17'd0;
      col_op_q    <= 8'd42;
      row_op_q    <= 8'd43;
      wr_op_q     <= 8'd44;
      rd_op_q     <= 8'd46;
      x_off_q     <= 16'd0;
      y_off_q     <= 16'd0;
    end else begin
      phase_q     <= phase_d;
      byte_idx_q  <= byte_idx_d;
      high_q      <= high_d;
      col_first_q <= col_first_d;
      col_last_q  <= col_last_d;
      row_first_q <= row_first_d;
      row_last_q  <= row_last_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_COL_OP:   col_op_q <= cfg_data_i[7:0];
          CFG_ROW_OP:   row_op_q <= cfg_data_i[7:0];
          CFG_WR_OP:    wr_op_q  <= cfg_data_i[7:0];
          CFG_RD_OP:    rd_op_q  <= cfg_data_i[7:0];
          CFG_X_OFFSET: x_off_q  <= cfg_data_i;
          CFG_Y_OFFSET: y_off_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // a transfer never writes and reads the store at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(req_o.we && req_o.re))
    else $error("store write and read requested together");

  // a completed set sequence always leaves the set phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_data_i && (phase_q == PH_COLSET || phase_q == PH_ROWSET) &&
     byte_idx_q == 2'd3) |=> (phase_q == PH_IGNORE))
    else $error("window set sequence did not terminate");

  // walker column never leaves 16 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni) !cur_col_q[16])
    else $error("column position overflow");

endmodule

`default_nettype wire

// ===== rtl/spi_tft_window_framebuffer_core.sv =====
// Top level: SPI TFT command/data front end with windowed RGB frame store.
`default_nettype none

// SPI byte stream in, one reply byte out per byte. Every byte is a single
// transfer on the input channel and yields exactly one transfer on the output
// channel, in order. A byte is taken every cycle when the output side keeps
// up. The store read and stage 1 load when a byte is accepted; the output
// register loads from stage 1 when it advances, which waits while the output
// side stalls. The frame store is a single-port 76800 x 24-bit RAM
// (320 x 240, 0xRRGGBB); it has no reset or clearing pass, so pixels must
// be written before they are read back. Configuration writes are always
// accepted (cfg_ready_o high) and should only be issued while the block is
// idle; indexes past the register list are ignored.
module spi_tft_window_framebuffer_core
  import stwf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CFG_IW-1:0] cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              is_data_i,
  input  wire logic [7:0]        bus_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             reply_byte_o
);

  logic        accept;
  reply_info_t info;
  mem_req_t    req;
  logic [PIX_W-1:0] rdata;

  logic        s1_valid_q;
  reply_info_t s1_info_q;
  logic [7:0]  s1_byte_q;
  logic        s1_adv;
  logic [7:0]  s1_reply;
  logic        out_valid_q;
  logic [7:0]  reply_q;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign accept      = in_valid_i && in_ready_o;

  stwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (accept),
    .is_data_i   (is_data_i),
    .bus_byte_i  (bus_byte_i),
    .info_o      (info),
    .req_o       (req)
  );

  stwf_ram #(
    .DEPTH (PIXELS),
    .WIDTH (PIX_W),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req.we),
    .re_i    (req.re),
    .addr_i  (req.addr),
    .wdata_i (req.wdata),
    .rdata_o (rdata)
  );

  // read data holds while stage 1 stalls since no new read is issued
  always_comb begin
    case (s1_info_q.src)
      SRC_ECHO: s1_reply = s1_byte_q;
      SRC_PIXEL: begin
        case (s1_info_q.chan)
          2'd0:    s1_reply = rdata[23:16] & READ_MASK;
          2'd1:    s1_reply = rdata[15:8] & READ_MASK;
          default: s1_reply = rdata[7:0] & READ_MASK;
        endcase
      end
      default: s1_reply = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
      s1_byte_q <= bus_byte_i;
    end
    if (s1_adv) begin
      reply_q <= s1_reply;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_byte_o = reply_q;

  // a store read issued for a byte lines up with that byte in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req.re) |=> (s1_valid_q && s1_info_q.src == SRC_PIXEL))
    else $error("store read not aligned with pixel reply");

  // a stalled stage 1 keeps its byte, and its pixel data when it waits on one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_byte_q) &&
                                 (s1_info_q.src != SRC_PIXEL || $stable(rdata))))
    else $error("stage 1 lost data while stalled");

  // a stalled stage 1 never overlaps a new store read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !req.re)
    else $error("store read while stage 1 stalled");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for spi_tft_window_framebuffer_core: directed and random SPI streams.
`timescale 1ns / 100ps

module tb;
  import stwf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_PIX        = 48;

  typedef enum logic [2:0] {
    PH_IDLE_INIT,
    PH_SKIP,
    PH_COL,
    PH_ROW,
    PH_WR,
    PH_RD_DUMMY,
    PH_RD
  } stream_phase_e;

  typedef struct packed {
    logic       d;
    logic [7:0] b;
    logic       known;
    logic [7:0] want;
  } dir_row_t;

  // known replies only where they are obvious: echoes, zeros, full-scale pixels
  localparam dir_row_t DIR_ROWS [30] = '{
    '{1'b1, 8'h5A, 1'b1, 8'h00},  // data before any command
    '{1'b0, 8'h00, 1'b1, 8'h00},  // unknown commands
    '{1'b0, 8'hFF, 1'b1, 8'hFF},
    '{1'b1, 8'hA5, 1'b1, 8'hA5},  // data while ignoring
    '{1'b0, 8'h2A, 1'b1, 8'h2A},  // columns 5..6
    '{1'b1, 8'h00, 1'b1, 8'h00},
    '{1'b1, 8'h05, 1'b1, 8'h05},
    '{1'b1, 8'h00, 1'b1, 8'h00},
    '{1'b1, 8'h06, 1'b1, 8'h06},
    '{1'b0, 8'h2B, 1'b1, 8'h2B},  // row 7 only
    '{1'b1, 8'h00, 1'b1, 8'h00},
    '{1'b1, 8'h07, 1'b1, 8'h07},
    '{1'b1, 8'h00, 1'b1, 8'h00},
    '{1'b1, 8'h07, 1'b1, 8'h07},
    '{1'b0, 8'h2C, 1'b1, 8'h2C},  // white then black
    '{1'b1, 8'hFF, 1'b1, 8'hFF},
    '{1'b1, 8'hFF, 1'b1, 8'hFF},
    '{1'b1, 8'h00, 1'b1, 8'h00},
    '{1'b1, 8'h00, 1'b1, 8'h00},
    '{1'b0, 8'h2E, 1'b1, 8'h2E},  // read back, dummy byte first
    '{1'b1, 8'h33, 1'b1, 8'h33},
    '{1'b1, 8'h00, 1'b1, 8'hFC},
    '{1'b1, 8'h00, 1'b1, 8'hFC},
    '{1'b1, 8'h00, 1'b1, 8'hFC},
    '{1'b1, 8'hFF, 1'b1, 8'h00},
    '{1'b1, 8'hFF, 1'b1, 8'h00},
    '{1'b1, 8'hFF, 1'b1, 8'h00},
    '{1'b0, 8'h2C, 1'b0, 8'h00},  // mid-scale pixel
    '{1'b1, 8'h84, 1'b0, 8'h00},
    '{1'b1, 8'h10, 1'b0, 8'h00}
  };

  localparam logic [CFG_IW-1:0] REG_ORDER [6] = '{
    CFG_COL_OP, CFG_ROW_OP, CFG_WR_OP, CFG_RD_OP, CFG_X_OFFSET, CFG_Y_OFFSET
  };

  // register values per run phase, in REG_ORDER; phase 0 keeps reset values
  localparam logic [15:0] CFG_PLAN [6][6] = '{
    '{16'h002A, 16'h002B, 16'h002C, 16'h002E, 16'h0000, 16'h0000},
    '{16'h00FF, 16'h0000, 16'h0080, 16'h0001, 16'h0000, 16'h0000},
    '{16'h002A, 16'h002B, 16'h002C, 16'h002E, 16'hFFFF, 16'hFFFF},
    '{16'h0010, 16'h0011, 16'h0012, 16'h0013, 16'h0064, 16'h0032},
    '{16'h002A, 16'h002A, 16'h002A, 16'h002A, 16'h0000, 16'h0000},
    '{16'h002A, 16'h002B, 16'h002C, 16'h002E, 16'h0007, 16'h0003}
  };
  localparam int PHASE_ITEMS [6] = '{160, 160, 140, 160, 80, 160};

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [15:0]       cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              is_data_i;
  logic [7:0]        bus_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        reply_byte_o;

  spi_tft_window_framebuffer_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .is_data_i    (is_data_i),
    .bus_byte_i   (bus_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reply_byte_o (reply_byte_o)
  );

  always #2 clk_i = ~clk_i;

  // display controller state as seen from the bus
  logic [7:0]    op_col, op_row, op_wr, op_rd;
  logic [15:0]   off_x, off_y;
  stream_phase_e ph;
  logic [1:0]    bidx;
  logic [7:0]    hi_byte;
  logic [15:0]   col_lo, col_hi, row_lo, row_hi;
  logic [16:0]   col_at, row_at;
  logic [23:0]   pix_mem [PIXELS];
  bit            pix_seen [PIXELS];

  logic [7:0] expected_replies [$];
  int         err_cnt;
  int         stim_count;
  int         quiet_cycles;
  int         stall_left;
  bit         rx_free;
  bit         hold_out_req;
  bit         tx_no_gaps;

  function automatic void reset_display();
    op_col = 8'd42;
    op_row = 8'd43;
    op_wr  = 8'd44;
    op_rd  = 8'd46;
    off_x  = '0;
    off_y  = '0;
    ph      = PH_IDLE_INIT;
    bidx    = '0;
    hi_byte = '0;
    col_lo  = '0;
    col_hi  = '0;
    row_lo  = '0;
    row_hi  = '0;
    col_at  = '0;
    row_at  = '0;
    foreach (pix_seen[i]) pix_seen[i] = 1'b0;
  endfunction

  function automatic void write_reg(logic [CFG_IW-1:0] idx, logic [15:0] v);
    case (idx)
      CFG_COL_OP:   op_col = v[7:0];
      CFG_ROW_OP:   op_row = v[7:0];
      CFG_WR_OP:    op_wr  = v[7:0];
      CFG_RD_OP:    op_rd  = v[7:0];
      CFG_X_OFFSET: off_x  = v;
      CFG_Y_OFFSET: off_y  = v;
      default: ;
    endcase
  endfunction

  function automatic bit pixel_addr(output int unsigned a);
    int x, y;
    x = int'(col_at) - int'(off_x);
    y = int'(row_at) - int'(off_y);
    a = 0;
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return 1'b0;
    a = x + SCREEN_WIDTH * y;
    return 1'b1;
  endfunction

  // column first, wrap to the window start and step the row; past the last row, done
  function automatic void step_window();
    col_at = col_at + 17'd1;
    if (col_at > {1'b0, col_hi}) begin
      col_at = {1'b0, col_lo};
      row_at = row_at + 17'd1;
      if (row_at > {1'b0, row_hi}) ph = PH_SKIP;
    end
  endfunction

  function automatic bit read_forbidden();
    int unsigned a;
    bit hit;
    if (ph != PH_RD) return 1'b0;
    hit = pixel_addr(a);
    return hit && !pix_seen[a];
  endfunction

  function automatic logic [7:0] predict_reply(logic d, logic [7:0] b);
    logic [7:0]  reply;
    logic [15:0] word;
    int unsigned a;
    bit          hit;
    int          r, g, bl;
    reply = b;
    if (!d) begin
      bidx    = '0;
      hi_byte = '0;
      if (b == op_col) ph = PH_COL;
      else if (b == op_row) ph = PH_ROW;
      else if (b == op_wr) begin
        col_at = {1'b0, col_lo};
        row_at = {1'b0, row_lo};
        ph = PH_WR;
      end else if (b == op_rd) begin
        col_at = {1'b0, col_lo};
        row_at = {1'b0, row_lo};
        ph = PH_RD_DUMMY;
      end else ph = PH_SKIP;
    end else begin
      case (ph)
        PH_IDLE_INIT: reply = 8'h00;
        PH_COL, PH_ROW: begin
          if (!bidx[0]) begin
            hi_byte = b;
            bidx = bidx + 2'd1;
          end else begin
            word = {hi_byte, b};
            if (bidx == 2'd1) begin
              if (ph == PH_COL) col_lo = word;
              else row_lo = word;
              bidx = 2'd2;
            end else begin
              if (ph == PH_COL) col_hi = word;
              else row_hi = word;
              bidx = 2'd0;
              ph = PH_SKIP;
            end
          end
        end
        PH_WR: begin
          if (bidx == 2'd0) begin
            hi_byte = b;
            bidx = 2'd1;
          end else begin
            word = {hi_byte, b};
            hit = pixel_addr(a);
            if (hit) begin
              r  = int'(word[15:11]) * 255 / MAX5;
              g  = int'(word[10:5]) * 255 / MAX6;
              bl = int'(word[4:0]) * 255 / MAX5;
              pix_mem[a]  = {r[7:0], g[7:0], bl[7:0]};
              pix_seen[a] = 1'b1;
            end
            bidx = 2'd0;
            step_window();
          end
        end
        PH_RD_DUMMY: begin
          bidx = 2'd0;
          ph = PH_RD;
        end
        PH_RD: begin
          reply = 8'h00;
          hit = pixel_addr(a);
          if (hit) begin
            case (bidx)
              2'd0:    reply = pix_mem[a][23:16] & READ_MASK;
              2'd1:    reply = pix_mem[a][15:8] & READ_MASK;
              default: reply = pix_mem[a][7:0] & READ_MASK;
            endcase
          end
          if (bidx >= 2'd2) begin
            bidx = 2'd0;
            step_window();
          end else bidx = bidx + 2'd1;
        end
        default: ;
      endcase
    end
    return reply;
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(logic d, logic [7:0] b, logic known, logic [7:0] want);
    int         gap;
    logic [7:0] reply;
    gap = pick_gap();
    // never read a pixel that was never written: end the read with a command
    if (d && read_forbidden()) d = 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    is_data_i  <= d;
    bus_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    stim_count++;
    reply = predict_reply(d, b);
    expected_replies.push_back(known ? want : reply);
  endtask

  task automatic put(logic d, logic [7:0] b);
    send_byte(d, b, 1'b0, 8'h00);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic load_setting(int s);
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= REG_ORDER[i];
      cfg_data_i  <= CFG_PLAN[s][i];
      do @(posedge clk_i); while (!cfg_ready_o);
      write_reg(REG_ORDER[i], CFG_PLAN[s][i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_span(logic [15:0] off, int extent, output logic [15:0] lo,
                           output logic [15:0] hi);
    int r, len;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      lo  = off + 16'($urandom_range(0, extent - 1));
      len = $urandom_range(0, 5);
      hi  = (int'(lo) + len > 65535) ? 16'hFFFF : lo + 16'(len);
    end else if (r < 88) begin
      lo = 16'($urandom_range(0, 65535));
      hi = $urandom_range(0, 1) ? 16'hFFFF : lo;
    end else if (r < 95) begin
      // start after end
      lo = 16'($urandom_range(1, 65535));
      hi = 16'($urandom_range(0, int'(lo) - 1));
    end else begin
      lo = 16'h0000;
      hi = 16'hFFFF;
    end
  endtask

  task automatic set_window(logic [7:0] op, logic [15:0] lo, logic [15:0] hi);
    logic [31:0] w;
    int keep;
    w = {lo, hi};
    keep = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : 4;
    put(1'b0, op);
    for (int i = 0; i < keep; i++) put(1'b1, w[31 - 8*i -: 8]);
  endtask

  // set a window, fill it, read it back; now and then cut short or overrun
  task automatic window_frame();
    logic [15:0] c_lo, c_hi, r_lo, r_hi, word;
    int w, h, npix, r;
    pick_span(off_x, SCREEN_WIDTH, c_lo, c_hi);
    pick_span(off_y, SCREEN_HEIGHT, r_lo, r_hi);
    set_window(op_col, c_lo, c_hi);
    set_window(op_row, r_lo, r_hi);
    w = (c_hi >= c_lo) ? int'(c_hi) - int'(c_lo) + 1 : 1;
    h = (r_hi >= r_lo) ? int'(r_hi) - int'(r_lo) + 1 : 1;
    if (w > MAX_PIX) w = MAX_PIX;
    if (h > MAX_PIX) h = MAX_PIX;
    npix = (w * h > MAX_PIX) ? MAX_PIX : w * h;
    put(1'b0, op_wr);
    for (int p = 0; p < npix; p++) begin
      r = $urandom_range(0, 99);
      word = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
      put(1'b1, word[15:8]);
      if ($urandom_range(0, 39) != 0) put(1'b1, word[7:0]);
    end
    if ($urandom_range(0, 4) == 0) put(1'b1, 8'($urandom));
    if ($urandom_range(0, 4) != 0) begin
      put(1'b0, op_rd);
      put(1'b1, 8'($urandom));
      for (int p = 0; p < 3 * npix; p++) put(1'b1, 8'($urandom));
      if ($urandom_range(0, 4) == 0) put(1'b1, 8'($urandom));
    end
  endtask

  task automatic noise_burst(int n);
    for (int i = 0; i < n; i++) put(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // reply side: check in order, then pick next ready
  always @(posedge clk_i) begin : reply_side
    logic [7:0] want;
    int r;
    if (out_valid_o && out_ready_i) begin
      if (expected_replies.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected reply byte %h", reply_byte_o);
      end else begin
        want = expected_replies.pop_front();
        if (reply_byte_o !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("reply_byte mismatch: expected %h, got %h", want, reply_byte_o);
        end
      end
    end
    if (hold_out_req && stall_left == 0) begin
      stall_left = LONG_HOLD;
      hold_out_req = 1'b0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(0, 999);
      if (rx_free) begin
        if (r < 4) rx_free = 1'b0;
        out_ready_i <= 1'b1;
      end else if (r < 150) begin
        stall_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else if (r < 160) begin
        stall_left = $urandom_range(19, 59);
        out_ready_i <= 1'b0;
      end else begin
        if (r > 990) rx_free = 1'b1;
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int  phase_start;
    bit  held, paused;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    is_data_i    = 1'b0;
    bus_byte_i   = '0;
    out_ready_i  = 1'b0;
    err_cnt      = 0;
    stim_count   = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    rx_free      = 1'b0;
    hold_out_req = 1'b0;
    tx_no_gaps   = 1'b0;
    reset_display();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int s = 0; s < 6; s++) begin
      if (s > 0) begin
        drain();
        load_setting(s);
      end else begin
        for (int i = 0; i < $size(DIR_ROWS); i++)
          send_byte(DIR_ROWS[i].d, DIR_ROWS[i].b, DIR_ROWS[i].known, DIR_ROWS[i].want);
      end
      phase_start = stim_count;
      held = 1'b0;
      paused = 1'b0;
      while (stim_count - phase_start < PHASE_ITEMS[s]) begin
        tx_no_gaps = ($urandom_range(0, 9) < 3);
        if (!held && (s == 0 || s == 3) && stim_count - phase_start > PHASE_ITEMS[s] / 3) begin
          // stall the reply side while bytes keep coming, so the input backs up
          held = 1'b1;
          hold_out_req = 1'b1;
          tx_no_gaps = 1'b1;
          noise_burst(16);
        end
        if (!paused && stim_count - phase_start > PHASE_ITEMS[s] / 2) begin
          paused = 1'b1;
          drain();
        end
        if ($urandom_range(0, 9) < 8) window_frame();
        else noise_burst($urandom_range(1, 6));
      end
    end

    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stwf_pkg.sv
rtl/stwf_ram.sv
rtl/stwf_ctrl.sv
rtl/spi_tft_window_framebuffer_core.sv
bench/tb.sv
